// File: design/ctf_pkg.sv
// Shared types, constants and the arctangent table of the complementary tilt filter.
package ctf_pkg;

  localparam int RAW_W   = 16;
  localparam int TILT_W  = 24;
  localparam int ALPHA_W = 17;
  localparam int SCALE_W = 16;
  localparam int CFG_AW  = 2;
  localparam int CFG_DW  = 17;

  // Datapath widths: CORDIC vector, angle accumulator, rounded angle,
  // gyro estimate, multiplier operands, product and weighted sum.
  localparam int XY_W   = 27;
  localparam int Z_W    = 26;
  localparam int ANG_W  = 18;
  localparam int GEST_W = 41;
  localparam int GLO_W  = 24;
  localparam int MA_W   = 18;
  localparam int MB_W   = 25;
  localparam int PROD_W = MA_W + MB_W;
  localparam int SUM_W  = 64;
  localparam int RQ_W   = SUM_W - 32;

  localparam int ATAN_N  = 24;
  localparam int ATAN_IW = 5;
  localparam int ATAN_W  = 22;

  localparam logic [CFG_AW-1:0] CFG_ALPHA_ACCEL     = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_ALPHA_GYRO      = 2'd1;
  localparam logic [CFG_AW-1:0] CFG_GYRO_STEP_SCALE = 2'd2;

  localparam logic [ALPHA_W-1:0] ALPHA_ACCEL_RST     = 17'd1311;
  localparam logic [ALPHA_W-1:0] ALPHA_GYRO_RST      = 17'd64225;
  localparam logic [SCALE_W-1:0] GYRO_STEP_SCALE_RST = 16'd10230;

  localparam logic signed [Z_W-1:0]    DEG90_Q16  = 26'sd5898240;
  localparam logic signed [TILT_W-1:0] TILT_MAX   = 24'sh7FFFFF;
  localparam logic signed [TILT_W-1:0] TILT_MIN   = 24'sh800000;
  localparam logic signed [SUM_W-1:0]  ROUND_HALF = 64'sh0000_0000_8000_0000;

  typedef enum logic [2:0] {
    M_NONE,
    M_SCALE,
    M_ACCEL,
    M_GLO,
    M_GHI
  } mul_src_t;

  typedef enum logic [1:0] {
    S_HOLD,
    S_LOAD0,
    S_ADD16,
    S_ADD24
  } sum_op_t;

  typedef enum logic [2:0] {
    J_NEXT,
    J_GOTO,
    J_LOOP,
    J_AXIS,
    J_IN,
    J_OUT
  } jump_t;

  typedef enum logic [3:0] {
    U_IDLE,
    U_CLOAD,
    U_CITER,
    U_ANGLE,
    U_MACC,
    U_MGHI,
    U_SUMHI,
    U_STORE,
    U_OUT
  } ustep_t;

  typedef struct packed {
    logic     in_take;
    logic     cordic_load;
    logic     cordic_iter;
    logic     gest_load;
    logic     angle_load;
    mul_src_t mul;
    sum_op_t  sum;
    logic     result_store;
    logic     out_load;
    jump_t    jmp;
    ustep_t   target;
  } uop_t;

  typedef struct packed {
    logic iter_last;
    logic axis_second;
  } dp_stat_t;

  typedef struct packed {
    logic     in_valid;
    logic     out_busy;
    dp_stat_t dp;
  } seq_stat_t;

  // atan(2^-i) in degrees times 65536, rounded to nearest.
  function automatic logic [ATAN_W-1:0] atan_q16(logic [ATAN_IW-1:0] i);
    logic [ATAN_W-1:0] v;
    case (i)
      5'd0:    v = 22'd2949120;
      5'd1:    v = 22'd1740967;
      5'd2:    v = 22'd919879;
      5'd3:    v = 22'd466945;
      5'd4:    v = 22'd234379;
      5'd5:    v = 22'd117304;
      5'd6:    v = 22'd58666;
      5'd7:    v = 22'd29335;
      5'd8:    v = 22'd14668;
      5'd9:    v = 22'd7334;
      5'd10:   v = 22'd3667;
      5'd11:   v = 22'd1833;
      5'd12:   v = 22'd917;
      5'd13:   v = 22'd458;
      5'd14:   v = 22'd229;
      5'd15:   v = 22'd115;
      5'd16:   v = 22'd57;
      5'd17:   v = 22'd29;
      5'd18:   v = 22'd14;
      5'd19:   v = 22'd7;
      5'd20:   v = 22'd4;
      5'd21:   v = 22'd2;
      5'd22:   v = 22'd1;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

endpackage

// File: design/complementary_tilt_filter_core.sv
// Top level of the complementary tilt filter: configuration, handshake and output register.
//
// Use: each input item is one raw inertial sample (accelerometer x, y, z and
// gyro x, y, all signed 16 bit). It is accepted at a rising edge where
// in_valid is high and in_stall is low. Each item yields exactly one result
// item with the two filtered tilt angles in 1/256 degree and a flag that is
// set when either angle hit the 24-bit limit.
// The block works on one item at a time under a microcoded sequencer. Per
// axis it loads the CORDIC, runs CORDIC_STEPS micro-rotations, rounds the
// angle, multiply-accumulates through the single shared multiplier and
// stores the result; an accept step comes before and an output step after.
// The next item is taken only once the current result has moved to the
// output register, since the sequencer handles a single item at a time.
// The result sits in an output register, so the next item is accepted and
// processed while a result waits; if out_stall is still high when that next
// result is ready, the sequencer holds until the register frees up.
// Reset (rst_n low, synchronous) clears both stored angles to zero, loads
// the default weights and step scale and drops out_valid. Configuration
// writes go to cfg_addr 0, 1 or 2; other addresses are ignored.
module complementary_tilt_filter_core #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [ctf_pkg::RAW_W-1:0]    in_accel_x_raw,
  input  logic signed [ctf_pkg::RAW_W-1:0]    in_accel_y_raw,
  input  logic signed [ctf_pkg::RAW_W-1:0]    in_accel_z_raw,
  input  logic signed [ctf_pkg::RAW_W-1:0]    in_gyro_x_raw,
  input  logic signed [ctf_pkg::RAW_W-1:0]    in_gyro_y_raw,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [ctf_pkg::TILT_W-1:0]   out_tilt_first,
  output logic signed [ctf_pkg::TILT_W-1:0]   out_tilt_second,
  output logic                                out_clipped,
  input  logic                                cfg_we,
  input  logic        [ctf_pkg::CFG_AW-1:0]   cfg_addr,
  input  logic        [ctf_pkg::CFG_DW-1:0]   cfg_wdata
);
  import ctf_pkg::*;

  logic [ALPHA_W-1:0] alpha_accel_r;
  logic [ALPHA_W-1:0] alpha_gyro_r;
  logic [SCALE_W-1:0] gyro_step_scale_r;

  uop_t      uop;
  dp_stat_t  dp_stat;
  seq_stat_t seq_stat;

  logic                     in_fire;
  logic                     out_valid_r;
  logic                     out_busy;
  logic                     out_fire;
  logic signed [TILT_W-1:0] dp_tilt_first, dp_tilt_second;
  logic                     dp_clipped;

  // Input is open only while the sequencer sits at its accept step.
  assign in_stall = !uop.in_take || !rst_n;
  assign in_fire  = in_valid && !in_stall;

  // The output register is busy while it holds an item the receiver stalls.
  assign out_busy = out_valid_r && out_stall;
  assign out_fire = uop.out_load && !out_busy;

  assign seq_stat.in_valid = in_valid;
  assign seq_stat.out_busy = out_busy;
  assign seq_stat.dp       = dp_stat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_accel_r     <= ALPHA_ACCEL_RST;
      alpha_gyro_r      <= ALPHA_GYRO_RST;
      gyro_step_scale_r <= GYRO_STEP_SCALE_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_ALPHA_ACCEL:     alpha_accel_r     <= cfg_wdata[ALPHA_W-1:0];
        CFG_ALPHA_GYRO:      alpha_gyro_r      <= cfg_wdata[ALPHA_W-1:0];
        CFG_GYRO_STEP_SCALE: gyro_step_scale_r <= cfg_wdata[SCALE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  ctf_useq u_useq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (seq_stat),
    .uop   (uop)
  );

  ctf_dpath #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .uop             (uop),
    .in_fire         (in_fire),
    .accel_x_raw     (in_accel_x_raw),
    .accel_y_raw     (in_accel_y_raw),
    .accel_z_raw     (in_accel_z_raw),
    .gyro_x_raw      (in_gyro_x_raw),
    .gyro_y_raw      (in_gyro_y_raw),
    .alpha_accel     (alpha_accel_r),
    .alpha_gyro      (alpha_gyro_r),
    .gyro_step_scale (gyro_step_scale_r),
    .stat            (dp_stat),
    .tilt_first      (dp_tilt_first),
    .tilt_second     (dp_tilt_second),
    .clipped         (dp_clipped)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_fire) begin
      out_tilt_first  <= dp_tilt_first;
      out_tilt_second <= dp_tilt_second;
      out_clipped     <= dp_clipped;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// File: design/ctf_useq.sv
// Microcode sequencer: step counter, control store and jump logic.
module ctf_useq (
  input  logic               clk,
  input  logic               rst_n,
  input  ctf_pkg::seq_stat_t stat,
  output ctf_pkg::uop_t      uop
);
  import ctf_pkg::*;

  ustep_t pc_r;
  ustep_t pc_nxt;

  // Control store.
  always_comb begin
    uop = '0;
    uop.mul    = M_NONE;
    uop.sum    = S_HOLD;
    uop.jmp    = J_NEXT;
    uop.target = U_IDLE;
    case (pc_r)
      U_IDLE: begin
        uop.in_take = 1'b1;
        uop.jmp     = J_IN;
      end
      U_CLOAD: begin
        uop.cordic_load = 1'b1;
        uop.mul         = M_SCALE;
      end
      U_CITER: begin
        uop.cordic_iter = 1'b1;
        uop.gest_load   = 1'b1;
        uop.jmp         = J_LOOP;
        uop.target      = U_CITER;
      end
      U_ANGLE: begin
        uop.angle_load = 1'b1;
        uop.mul        = M_GLO;
      end
      U_MACC: begin
        uop.mul = M_ACCEL;
        uop.sum = S_LOAD0;
      end
      U_MGHI: begin
        uop.mul = M_GHI;
        uop.sum = S_ADD16;
      end
      U_SUMHI: begin
        uop.sum = S_ADD24;
      end
      U_STORE: begin
        uop.result_store = 1'b1;
        uop.jmp          = J_AXIS;
        uop.target       = U_CLOAD;
      end
      U_OUT: begin
        uop.out_load = 1'b1;
        uop.jmp      = J_OUT;
        uop.target   = U_IDLE;
      end
      default: begin
        uop.jmp    = J_GOTO;
        uop.target = U_IDLE;
      end
    endcase
  end

  // Next step.
  always_comb begin
    pc_nxt = ustep_t'(pc_r + 4'd1);
    case (uop.jmp)
      J_NEXT:  pc_nxt = ustep_t'(pc_r + 4'd1);
      J_GOTO:  pc_nxt = uop.target;
      J_LOOP:  pc_nxt = stat.dp.iter_last ? ustep_t'(pc_r + 4'd1) : uop.target;
      J_AXIS:  pc_nxt = stat.dp.axis_second ? ustep_t'(pc_r + 4'd1) : uop.target;
      J_IN:    pc_nxt = stat.in_valid ? ustep_t'(pc_r + 4'd1) : pc_r;
      J_OUT:   pc_nxt = stat.out_busy ? pc_r : uop.target;
      default: pc_nxt = U_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= U_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  a_take_starts_cordic: assert property (@(posedge clk) disable iff (!rst_n)
    (uop.in_take && stat.in_valid) |=> uop.cordic_load)
    else $error("accepted item did not start the CORDIC load");

  a_last_iter_rounds: assert property (@(posedge clk) disable iff (!rst_n)
    (uop.cordic_iter && stat.dp.iter_last) |=> uop.angle_load)
    else $error("last CORDIC iteration not followed by angle rounding");

  a_second_store_outputs: assert property (@(posedge clk) disable iff (!rst_n)
    (uop.result_store && stat.dp.axis_second) |=> uop.out_load)
    else $error("second axis stored without moving to output");

endmodule

// File: design/ctf_dpath.sv
// Datapath: sample registers, CORDIC vectoring unit, shared multiplier and accumulator.
module ctf_dpath #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  ctf_pkg::uop_t                          uop,
  input  logic                                   in_fire,
  input  logic signed [ctf_pkg::RAW_W-1:0]       accel_x_raw,
  input  logic signed [ctf_pkg::RAW_W-1:0]       accel_y_raw,
  input  logic signed [ctf_pkg::RAW_W-1:0]       accel_z_raw,
  input  logic signed [ctf_pkg::RAW_W-1:0]       gyro_x_raw,
  input  logic signed [ctf_pkg::RAW_W-1:0]       gyro_y_raw,
  input  logic        [ctf_pkg::ALPHA_W-1:0]     alpha_accel,
  input  logic        [ctf_pkg::ALPHA_W-1:0]     alpha_gyro,
  input  logic        [ctf_pkg::SCALE_W-1:0]     gyro_step_scale,
  output ctf_pkg::dp_stat_t                      stat,
  output logic signed [ctf_pkg::TILT_W-1:0]      tilt_first,
  output logic signed [ctf_pkg::TILT_W-1:0]      tilt_second,
  output logic                                   clipped
);
  import ctf_pkg::*;

  localparam int IW = $clog2(CORDIC_STEPS);
  localparam logic [IW-1:0] ITER_LAST = IW'(CORDIC_STEPS - 1);

  logic signed [RAW_W-1:0]  ax_r, ay_r, az_r, gx_r, gy_r;
  logic                     axis_r;
  logic                     clip_r;
  logic signed [XY_W-1:0]   x_r, y_r;
  logic signed [Z_W-1:0]    z_r;
  logic                     zero_r;
  logic [IW-1:0]            iter_r;
  logic signed [GEST_W-1:0] gest_r;
  logic signed [ANG_W-1:0]  ang_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [SUM_W-1:0]  sum_r;
  logic signed [TILT_W-1:0] prev_first_r, prev_second_r;

  logic signed [RAW_W-1:0]  num_v, gyro_v;
  logic signed [TILT_W-1:0] prev_v;
  logic signed [XY_W-1:0]   xi, yi, lx, ly, xs, ys;
  logic signed [Z_W-1:0]    lz, at_v;
  logic signed [XY_W-1:0]   rnd_v;
  logic signed [MA_W-1:0]   mul_a;
  logic signed [MB_W-1:0]   mul_b;
  logic signed [SUM_W-1:0]  prod_ext, rsum;
  logic signed [RQ_W-1:0]   rq;
  logic signed [TILT_W-1:0] sat_v;
  logic                     sat_hit;

  assign num_v  = axis_r ? ay_r : ax_r;
  assign gyro_v = axis_r ? gx_r : gy_r;
  assign prev_v = axis_r ? prev_second_r : prev_first_r;

  // Operands scaled by 256, then folded into the right half plane.
  assign xi = {{(XY_W-RAW_W-8){az_r[RAW_W-1]}}, az_r, 8'b0};
  assign yi = {{(XY_W-RAW_W-8){num_v[RAW_W-1]}}, num_v, 8'b0};

  always_comb begin
    lx = xi;
    ly = yi;
    lz = '0;
    if (xi[XY_W-1]) begin
      if (!yi[XY_W-1]) begin
        lx = yi;
        ly = -xi;
        lz = DEG90_Q16;
      end else begin
        lx = -yi;
        ly = xi;
        lz = -DEG90_Q16;
      end
    end
  end

  assign xs   = x_r >>> iter_r;
  assign ys   = y_r >>> iter_r;
  assign at_v = $signed({{(Z_W-ATAN_W){1'b0}}, atan_q16(ATAN_IW'(iter_r))});

  // Negate and round to 1/256 degree.
  assign rnd_v = $signed(XY_W'(28'sd128)) - XY_W'(z_r);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (uop.mul)
      M_SCALE: begin
        mul_a = MA_W'(gyro_v);
        mul_b = $signed({{(MB_W-SCALE_W){1'b0}}, gyro_step_scale});
      end
      M_ACCEL: begin
        mul_a = $signed({{(MA_W-ALPHA_W){1'b0}}, alpha_accel});
        mul_b = MB_W'(ang_r);
      end
      M_GLO: begin
        mul_a = $signed({{(MA_W-ALPHA_W){1'b0}}, alpha_gyro});
        mul_b = $signed({{(MB_W-GLO_W){1'b0}}, gest_r[GLO_W-1:0]});
      end
      M_GHI: begin
        // The upper part of the gyro estimate carries its sign.
        mul_a = $signed({{(MA_W-ALPHA_W){1'b0}}, alpha_gyro});
        mul_b = MB_W'($signed(gest_r[GEST_W-1:GLO_W]));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_ext = SUM_W'(prod_r);
  assign rsum     = sum_r + ROUND_HALF;
  assign rq       = rsum[SUM_W-1:32];

  always_comb begin
    sat_v   = rq[TILT_W-1:0];
    sat_hit = 1'b0;
    if (rq > RQ_W'(TILT_MAX)) begin
      sat_v   = TILT_MAX;
      sat_hit = 1'b1;
    end else if (rq < RQ_W'(TILT_MIN)) begin
      sat_v   = TILT_MIN;
      sat_hit = 1'b1;
    end
  end

  // Sample and per-item control.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      ax_r <= accel_x_raw;
      ay_r <= accel_y_raw;
      az_r <= accel_z_raw;
      gx_r <= gyro_x_raw;
      gy_r <= gyro_y_raw;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      axis_r        <= 1'b0;
      clip_r        <= 1'b0;
      prev_first_r  <= '0;
      prev_second_r <= '0;
    end else begin
      if (in_fire) begin
        axis_r <= 1'b0;
        clip_r <= 1'b0;
      end else if (uop.result_store) begin
        axis_r <= 1'b1;
        clip_r <= clip_r | sat_hit;
        if (axis_r) begin
          prev_second_r <= sat_v;
        end else begin
          prev_first_r <= sat_v;
        end
      end
    end
  end

  // CORDIC vectoring unit, one micro-rotation per cycle.
  always_ff @(posedge clk) begin
    if (uop.cordic_load) begin
      x_r    <= lx;
      y_r    <= ly;
      z_r    <= lz;
      zero_r <= (num_v == '0) && (az_r == '0);
      iter_r <= '0;
    end else if (uop.cordic_iter) begin
      iter_r <= iter_r + 1'b1;
      if (!y_r[XY_W-1]) begin
        x_r <= x_r + ys;
        y_r <= y_r - xs;
        z_r <= z_r + at_v;
      end else begin
        x_r <= x_r - ys;
        y_r <= y_r + xs;
        z_r <= z_r - at_v;
      end
    end
  end

  // Shared multiplier and weighted-sum accumulator.
  always_ff @(posedge clk) begin
    if (uop.mul != M_NONE) begin
      prod_r <= mul_a * mul_b;
    end
    if (uop.gest_load) begin
      gest_r <= (GEST_W'(prev_v) <<< 16) + GEST_W'(prod_r);
    end
    if (uop.angle_load) begin
      ang_r <= zero_r ? '0 : rnd_v[ANG_W+7:8];
    end
    case (uop.sum)
      S_LOAD0: sum_r <= prod_ext;
      S_ADD16: sum_r <= sum_r + (prod_ext <<< 16);
      S_ADD24: sum_r <= sum_r + (prod_ext <<< 24);
      default: sum_r <= sum_r;
    endcase
  end

  assign stat.iter_last   = (iter_r == ITER_LAST);
  assign stat.axis_second = axis_r;
  assign tilt_first       = prev_first_r;
  assign tilt_second      = prev_second_r;
  assign clipped          = clip_r;

endmodule
